/* rtl/rsca_pkg.sv */
// shared constants, request codes, command op codes and width helpers
// for the row span coverage accumulator; no dependencies
`default_nettype none

package rsca_pkg;

    // fixed field widths of the stream items
    localparam int REQ_W     = 2;
    localparam int X_W       = 19;
    localparam int COLUMN_W  = 10;
    localparam int PIX_W     = 8;
    localparam int ROW_CFG_W = 11;

    // default row geometry
    localparam int RSCA_ROW_PIXELS = 1024;
    localparam int RSCA_FRAC_BITS  = 8;
    localparam logic [ROW_CFG_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // memory word layout: eight pixels per word
    localparam int PPW       = 8;
    localparam int PPW_SHIFT = 3;

    // per column coverage gain and edge add width (0..51)
    localparam logic [PIX_W-1:0] COV_STEP = 8'h33;
    localparam int ADD_W = 6;

    // command queue depth
    localparam int CMD_FIFO_DEPTH = 4;

    // request codes on the input tuser
    localparam logic [REQ_W-1:0] REQ_SPAN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // queued command kinds
    typedef enum logic [1:0] {
        OP_SPAN  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } cmd_op_t;

    // number of memory words for a row
    function automatic int word_count(input int row_pixels);
        return (row_pixels + PPW - 1) >> PPW_SHIFT;
    endfunction

    // word index width, at least one bit
    function automatic int idx_width(input int row_pixels);
        int words;
        words = word_count(row_pixels);
        return (words > 1) ? $clog2(words) : 1;
    endfunction

    // column width: word index plus lane
    function automatic int col_width(input int row_pixels);
        return idx_width(row_pixels) + PPW_SHIFT;
    endfunction

    // packed command width: op, first, last, first and last edge adds, read column
    function automatic int cmd_width(input int row_pixels);
        return 2 + 2 * col_width(row_pixels) + 2 * ADD_W + COLUMN_W;
    endfunction

    // edge pixel add with saturation at full coverage
    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] pix,
                                                 input logic [ADD_W-1:0] add);
        logic [PIX_W:0] sum;
        sum = {1'b0, pix} + {{(PIX_W + 1 - ADD_W){1'b0}}, add};
        return sum[PIX_W] ? {PIX_W{1'b1}} : sum[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rsca_cmd_fifo.sv */
// short command queue between the span front end and the row back end
// depends on rsca_pkg for the queue depth
`default_nettype none

module rsca_cmd_fifo
    import rsca_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      head_data
);

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rsca_front.sv */
// request front end: classifies beats, drops void spans and unused request codes,
// works out span edge columns and edge coverage adds; depends on rsca_pkg
`default_nettype none

module rsca_front
    import rsca_pkg::*;
#(
    parameter int ROW_PIXELS = RSCA_ROW_PIXELS,
    parameter int FRAC_BITS  = RSCA_FRAC_BITS
) (
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [REQ_W-1:0]               req_type,
    input  wire logic signed [X_W-1:0]          start_x,
    input  wire logic signed [X_W-1:0]          end_x,
    input  wire logic [COLUMN_W-1:0]            column,
    input  wire logic [ROW_CFG_W-1:0]           row_width,
    output logic                                push,
    output logic [cmd_width(ROW_PIXELS)-1:0]    push_data,
    input  wire logic                           queue_full
);

    localparam int COL_W  = col_width(ROW_PIXELS);
    localparam int WEFF_W = $clog2(ROW_PIXELS + 1);
    localparam int LIM_W  = WEFF_W + FRAC_BITS + 1;
    localparam int CALC_W = ((LIM_W > X_W) ? LIM_W : X_W) + 1;
    localparam int COV_W  = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 7;

    typedef struct packed {
        cmd_op_t              op;
        logic [COL_W-1:0]     first_col;
        logic [COL_W-1:0]     last_col;
        logic [ADD_W-1:0]     add_first;
        logic [ADD_W-1:0]     add_last;
        logic [COLUMN_W-1:0]  column;
    } cmd_t;

    logic [WEFF_W-1:0]        w_eff;
    logic signed [CALC_W-1:0] s_w, e_w, w_w, lim_w;
    logic signed [CALC_W-1:0] s_col, e_col, first_w, last_w;
    logic                     s_neg, last_clamp, span_void;
    logic [COV_W-1:0]         unit_cov, s_frac, e_frac, e_rel_first, c_first, c_last;
    logic [PROD_W-1:0]        prod_first, prod_last;
    logic                     keep;
    cmd_t                     cmd;

    // row width in use, limited to 1..ROW_PIXELS
    always_comb begin
        if (row_width == '0) begin
            w_eff = WEFF_W'(1);
        end else if (32'(row_width) > ROW_PIXELS) begin
            w_eff = WEFF_W'(ROW_PIXELS);
        end else begin
            w_eff = WEFF_W'(row_width);
        end
    end

    // span bounds in a common signed width
    assign s_w   = CALC_W'(start_x);
    assign e_w   = CALC_W'(end_x);
    assign w_w   = $signed(CALC_W'(w_eff));
    assign lim_w = $signed(CALC_W'(w_eff) << FRAC_BITS);
    assign s_neg = start_x[X_W-1];
    assign s_col = s_w >>> FRAC_BITS;
    assign e_col = e_w >>> FRAC_BITS;

    assign span_void  = (s_w >= lim_w) || end_x[X_W-1] || (e_w < s_w);
    assign first_w    = s_neg ? '0 : s_col;
    assign last_clamp = (e_col >= w_w);
    assign last_w     = last_clamp ? (w_w - CALC_W'(1)) : e_col;

    // fractional coverage of the first and last edge columns
    assign unit_cov    = COV_W'(1) << FRAC_BITS;
    assign s_frac      = s_neg ? '0 : {1'b0, start_x[FRAC_BITS-1:0]};
    assign e_frac      = {1'b0, end_x[FRAC_BITS-1:0]};
    assign e_rel_first = (e_col > first_w) ? unit_cov : e_frac;
    assign c_first     = e_rel_first - s_frac;
    assign c_last      = last_clamp ? unit_cov : e_frac;

    // coverage times 51, scaled back down
    assign prod_first = PROD_W'(c_first) * PROD_W'(COV_STEP);
    assign prod_last  = PROD_W'(c_last) * PROD_W'(COV_STEP);

    // classify the beat
    always_comb begin
        cmd.op        = OP_SPAN;
        cmd.first_col = COL_W'(first_w);
        cmd.last_col  = COL_W'(last_w);
        cmd.add_first = prod_first[FRAC_BITS+ADD_W-1:FRAC_BITS];
        cmd.add_last  = prod_last[FRAC_BITS+ADD_W-1:FRAC_BITS];
        cmd.column    = column;
        keep          = 1'b0;
        case (req_type)
            REQ_SPAN: begin
                keep = !span_void;
            end
            REQ_READ: begin
                cmd.op = OP_READ;
                keep   = 1'b1;
            end
            REQ_CLEAR: begin
                cmd.op = OP_CLEAR;
                keep   = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready   = !queue_full;
    assign push      = s_valid && !queue_full && keep;
    assign push_data = cmd;

endmodule

`default_nettype wire

/* rtl/rsca_back.sv */
// row back end: coverage memory of eight-pixel words with per-word valid
// flops, span read-modify-write sweep, pixel reads; depends on rsca_pkg
`default_nettype none

module rsca_back
    import rsca_pkg::*;
#(
    parameter int ROW_PIXELS = RSCA_ROW_PIXELS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    input  wire logic [cmd_width(ROW_PIXELS)-1:0] cmd_data,
    output logic                               cmd_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [PIX_W-1:0]                   pixel_value,
    output logic [COLUMN_W-1:0]                pixel_column
);

    localparam int WORDS  = word_count(ROW_PIXELS);
    localparam int IDX_W  = idx_width(ROW_PIXELS);
    localparam int COL_W  = col_width(ROW_PIXELS);
    localparam int WORD_W = PPW * PIX_W;

    typedef struct packed {
        cmd_op_t              op;
        logic [COL_W-1:0]     first_col;
        logic [COL_W-1:0]     last_col;
        logic [ADD_W-1:0]     add_first;
        logic [ADD_W-1:0]     add_last;
        logic [COLUMN_W-1:0]  column;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SPAN = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               head;
    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   cur_word_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  mem [WORDS];
    logic [WORD_W-1:0]  rdata_reg;
    logic               rvalid_reg;
    logic [WORDS-1:0]   valid_reg;
    logic               mem_we, clear_all, out_load, span_done;
    logic [WORD_W-1:0]  old_word, new_word;
    logic               m_valid_reg;
    logic [PIX_W-1:0]   pixel_value_reg, pixel_read;
    logic [COLUMN_W-1:0] pixel_column_reg;

    assign head      = cmd_t'(cmd_data);
    assign span_done = (cur_word_reg == cmd_reg.last_col[COL_W-1:PPW_SHIFT]);

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        clear_all  = 1'b0;
        out_load   = 1'b0;
        rd_addr    = cur_word_reg + IDX_W'(1);
        case (state_reg)
            ST_IDLE: begin
                if (head.op == OP_READ) begin
                    rd_addr = IDX_W'(head.column[COLUMN_W-1:PPW_SHIFT]);
                end else begin
                    rd_addr = head.first_col[COL_W-1:PPW_SHIFT];
                end
                if (cmd_valid) begin
                    case (head.op)
                        OP_SPAN: begin
                            cmd_pop    = 1'b1;
                            state_next = ST_SPAN;
                        end
                        OP_READ: begin
                            if (!m_valid_reg || m_ready) begin
                                cmd_pop    = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        OP_CLEAR: begin
                            cmd_pop   = 1'b1;
                            clear_all = 1'b1;
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SPAN: begin
                mem_we = 1'b1;
                if (span_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word as stored, zero while not yet written since reset or clear
    assign old_word = rvalid_reg ? rdata_reg : '0;

    // per-lane span update of the current word
    always_comb begin
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        for (int l = 0; l < PPW; l++) begin
            col = {cur_word_reg, PPW_SHIFT'(l)};
            pix = old_word[l*PIX_W +: PIX_W];
            if (col == cmd_reg.first_col) begin
                new_word[l*PIX_W +: PIX_W] = sat_add(pix, cmd_reg.add_first);
            end else if (col == cmd_reg.last_col) begin
                new_word[l*PIX_W +: PIX_W] = sat_add(pix, cmd_reg.add_last);
            end else if ((col > cmd_reg.first_col) && (col < cmd_reg.last_col)) begin
                new_word[l*PIX_W +: PIX_W] = pix + COV_STEP;
            end else begin
                new_word[l*PIX_W +: PIX_W] = pix;
            end
        end
    end

    // pixel picked for a read beat
    always_comb begin
        if (32'(cmd_reg.column) < ROW_PIXELS) begin
            pixel_read = old_word[cmd_reg.column[PPW_SHIFT-1:0]*PIX_W +: PIX_W];
        end else begin
            pixel_read = '0;
        end
    end

    // coverage memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cur_word_reg] <= new_word;
        end
        rdata_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clear_all) begin
                valid_reg <= '0;
            end else if (mem_we) begin
                valid_reg[cur_word_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_word_reg <= rd_addr;
        rvalid_reg   <= valid_reg[rd_addr];
        if (cmd_pop) begin
            cmd_reg <= head;
        end
        if (out_load) begin
            pixel_value_reg  <= pixel_read;
            pixel_column_reg <= cmd_reg.column;
        end
    end

    assign m_valid      = m_valid_reg;
    assign pixel_value  = pixel_value_reg;
    assign pixel_column = pixel_column_reg;

endmodule

`default_nettype wire

/* rtl/row_span_coverage_accumulator.sv */
// row span coverage accumulator: a span sweeps one eight-pixel memory word per
// cycle in the back end; input beats queue in a four-entry command fifo.
// reset clears the whole row at once through per-word valid flops and sets
// row_width to 1024.
`default_nettype none

module row_span_coverage_accumulator
    import rsca_pkg::*;
#(
    parameter int ROW_PIXELS = RSCA_ROW_PIXELS,
    parameter int FRAC_BITS  = RSCA_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: row_width
    input  wire logic                 cfg_we,
    input  wire logic [ROW_CFG_W-1:0] cfg_wdata,
    // request beats
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,  // start_x, end_x, column
    input  wire logic [REQ_W-1:0]     s_axis_tuser,  // req_type
    // read result beats
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata   // pixel_value, pixel_column
);

    localparam int CMD_W = cmd_width(ROW_PIXELS);

    logic [ROW_CFG_W-1:0] row_width_reg;
    logic                 push, queue_full, pop, queue_nonempty;
    logic [CMD_W-1:0]     push_data, head_data;
    logic [PIX_W-1:0]     pixel_value;
    logic [COLUMN_W-1:0]  pixel_column;

    // row width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_we) begin
            row_width_reg <= cfg_wdata;
        end
    end

    rsca_front #(
        .ROW_PIXELS (ROW_PIXELS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .req_type   (s_axis_tuser),
        .start_x    ($signed(s_axis_tdata[18:0])),
        .end_x      ($signed(s_axis_tdata[37:19])),
        .column     (s_axis_tdata[47:38]),
        .row_width  (row_width_reg),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    rsca_cmd_fifo #(
        .DATA_W (CMD_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_nonempty),
        .head_data (head_data)
    );

    rsca_back #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (queue_nonempty),
        .cmd_data     (head_data),
        .cmd_pop      (pop),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .pixel_value  (pixel_value),
        .pixel_column (pixel_column)
    );

    assign m_axis_tdata = {6'd0, pixel_column, pixel_value};

endmodule

`default_nettype wire

/* tb/sv/tb_row_span_coverage_accumulator.sv */
// self-checking testbench for row_span_coverage_accumulator: random and directed
// span, read and clear beats checked against an in-bench coverage row model
// depends on rsca_pkg and the accumulator rtl only
`default_nettype none

module tb_row_span_coverage_accumulator;
    import rsca_pkg::*;

    localparam int PIX_UNIT    = 1 << RSCA_FRAC_BITS;
    localparam int X_MAX       = 262143;
    localparam int X_MIN       = -262144;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 40;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        IDLE_TX27_RX79,
        IDLE_TX79_RX27,
        IDLE_NONE
    } idle_mode_t;

    // one request beat, fields as carried on the input channel
    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [X_W-1:0]      sx;
        logic [X_W-1:0]      ex;
        logic [COLUMN_W-1:0] col;
    } span_req_t;

    // one read result beat
    typedef struct packed {
        logic [PIX_W-1:0]    value;
        logic [COLUMN_W-1:0] col;
    } pixel_read_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [ROW_CFG_W-1:0] cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    wire logic            s_axis_tready;
    wire logic [47:0]     s_axis_tdata;
    wire logic [REQ_W-1:0] s_axis_tuser;
    wire logic            m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    wire logic [23:0]     m_axis_tdata;

    span_req_t   drv_req = '0;
    logic        s_beat_done = 1'b0;
    span_req_t   req_backlog[$];
    pixel_read_t pixel_expect[$];

    // model of the coverage row and of row_width
    logic [PIX_W-1:0]     cov_row [RSCA_ROW_PIXELS];
    logic [ROW_CFG_W-1:0] row_width_q = ROW_WIDTH_RESET;

    idle_mode_t idle_mode = IDLE_TX27_RX79;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int err_count = 0;
    int n_spans = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_unused = 0;
    int n_checked = 0;

    assign s_axis_tdata = {drv_req.col, drv_req.ex, drv_req.sx};
    assign s_axis_tuser = drv_req.req;

    row_span_coverage_accumulator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 20 units per period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // row width as the block uses it
    function automatic int eff_width();
        int w;
        w = int'(row_width_q);
        if (w < 1) w = 1;
        if (w > RSCA_ROW_PIXELS) w = RSCA_ROW_PIXELS;
        return w;
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int sext_x(logic [X_W-1:0] v);
        return int'({{(32 - X_W){v[X_W-1]}}, v});
    endfunction

    function automatic logic [X_W-1:0] to_x(int v);
        int c;
        c = clampi(v, X_MIN, X_MAX);
        return c[X_W-1:0];
    endfunction

    // edge column: fractional coverage times 51, saturated at full
    task automatic coverage_add_edge(int colx, int s, int e);
        int lo, hi, c, sum;
        lo = colx * PIX_UNIT;
        hi = lo + PIX_UNIT;
        c = clampi(e, lo, hi) - clampi(s, lo, hi);
        if (c < 0) c = 0;
        sum = int'(cov_row[colx]) + ((c * int'(COV_STEP)) >> RSCA_FRAC_BITS);
        cov_row[colx] = (sum > 255) ? 8'hFF : sum[PIX_W-1:0];
    endtask

    task automatic coverage_add_span(int s, int e);
        int w, first, stop, i;
        w = eff_width();
        if (s >= w * PIX_UNIT || e < 0 || e < s) return;
        first = (s < 0) ? 0 : (s >>> RSCA_FRAC_BITS);
        stop = (e >>> RSCA_FRAC_BITS) + 1;
        if (stop > w) stop = w;
        coverage_add_edge(first, s, e);
        if (stop - first >= 2) begin
            // interior columns wrap modulo 256
            for (i = first + 1; i < stop - 1; i++) begin
                cov_row[i] = cov_row[i] + COV_STEP;
            end
            coverage_add_edge(stop - 1, s, e);
        end
    endtask

    // apply one accepted beat to the row model
    task automatic coverage_predict(span_req_t r);
        pixel_read_t p;
        case (r.req)
            REQ_SPAN: begin
                n_spans++;
                coverage_add_span(sext_x(r.sx), sext_x(r.ex));
            end
            REQ_READ: begin
                n_reads++;
                p.value = (int'(r.col) < RSCA_ROW_PIXELS) ? cov_row[r.col] : '0;
                p.col = r.col;
                pixel_expect.insert(pixel_expect.size(), p);
            end
            REQ_CLEAR: begin
                n_clears++;
                foreach (cov_row[i]) cov_row[i] = '0;
            end
            default: begin
                n_unused++;
            end
        endcase
    endtask

    function automatic span_req_t make_read(int colx);
        span_req_t r;
        r.req = REQ_READ;
        r.sx = X_W'($urandom());
        r.ex = X_W'($urandom());
        r.col = COLUMN_W'(colx);
        return r;
    endfunction

    function automatic span_req_t make_span(int s, int e);
        span_req_t r;
        r.req = REQ_SPAN;
        r.sx = to_x(s);
        r.ex = to_x(e);
        r.col = COLUMN_W'($urandom());
        return r;
    endfunction

    // random beat; spans mostly local and well-formed, some corner shapes
    function automatic span_req_t make_request(int w, bit read_heavy);
        span_req_t r;
        int pick, shape, s, e, top;
        top = w * PIX_UNIT;
        r.sx = X_W'($urandom());
        r.ex = X_W'($urandom());
        r.col = COLUMN_W'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < (read_heavy ? 70 : 35)) begin
            r.req = REQ_READ;
            if ($urandom_range(0, 3) != 0) r.col = COLUMN_W'($urandom_range(0, w - 1));
        end else if (pick < 93) begin
            r.req = REQ_SPAN;
            shape = $urandom_range(0, 9);
            s = 0;
            e = 0;
            case (shape)
                0, 1, 2, 3, 4: begin
                    s = int'($urandom_range(0, top + PIX_UNIT)) - PIX_UNIT / 2;
                    e = s + int'($urandom_range(0, 4 * PIX_UNIT));
                end
                5, 6: begin
                    s = int'($urandom_range(0, top)) - PIX_UNIT;
                    e = s + int'($urandom_range(0, top));
                end
                7: begin
                    s = -int'($urandom_range(0, 262144));
                    e = int'($urandom_range(top - PIX_UNIT, X_MAX));
                end
                8: begin
                    s = sext_x(r.sx);
                    e = sext_x(r.ex);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            s = -int'($urandom_range(0, 262144));
                            e = -int'($urandom_range(1, 262144));
                        end
                        1: begin
                            s = int'($urandom_range(1, top));
                            e = s - int'($urandom_range(1, 300));
                        end
                        default: begin
                            s = top + int'($urandom_range(0, 1000));
                            e = s + int'($urandom_range(0, 1000));
                        end
                    endcase
                end
            endcase
            r.sx = to_x(s);
            r.ex = to_x(e);
        end else if (pick < 97) begin
            r.req = REQ_CLEAR;
        end else begin
            r.req = REQ_UNUSED;
        end
        return r;
    endfunction

    function automatic int sender_idle_pct(idle_mode_t m);
        return (m == IDLE_TX27_RX79) ? 27 : ((m == IDLE_TX79_RX27) ? 79 : 0);
    endfunction

    function automatic int receiver_idle_pct(idle_mode_t m);
        return (m == IDLE_TX27_RX79) ? 79 : ((m == IDLE_TX79_RX27) ? 27 : 0);
    endfunction

    // request driver, fed from the backlog, changes at the falling edge
    always @(negedge aclk) begin
        if (!s_axis_tvalid || s_beat_done) begin
            if (aresetn && req_backlog.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct(idle_mode)) begin
                drv_req <= req_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result ready, random stalls plus the long hold-off on request
    always @(negedge aclk) begin
        if (hold_left == 0 && hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct(idle_mode));
        end
    end

    // monitor: predict on each accepted request beat, check each result beat
    always @(posedge aclk) begin
        s_beat_done <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            coverage_predict(drv_req);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pixel_expect.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result beat, expected none, actual value %0d column %0d",
                             $time, m_axis_tdata[7:0], m_axis_tdata[17:8]);
            end else begin
                n_checked++;
                if (m_axis_tdata[7:0] !== pixel_expect[0].value) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: pixel_value mismatch (column %0d), expected %0d, actual %0d",
                                 $time, pixel_expect[0].col, pixel_expect[0].value,
                                 m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[17:8] !== pixel_expect[0].col) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: pixel_column mismatch, expected %0d, actual %0d",
                                 $time, pixel_expect[0].col, m_axis_tdata[17:8]);
                end
                void'(pixel_expect.pop_front());
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached, %0d results outstanding",
                     $time, CYCLE_LIMIT, pixel_expect.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // append one beat to the driver backlog
    task automatic backlog_add(span_req_t r);
        req_backlog.insert(req_backlog.size(), r);
    endtask

    // wait until every queued beat is taken and every result has come
    task automatic settle_all();
        while (req_backlog.size() != 0 || s_axis_tvalid || pixel_expect.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_row_width(logic [ROW_CFG_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        row_width_q = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one phase: new row width, random beats, a closing read, then drain
    task automatic run_phase(idle_mode_t mode, logic [ROW_CFG_W-1:0] width_val,
                             int n_items, bit hold, bit pause);
        int w, k;
        write_row_width(width_val);
        idle_mode = mode;
        w = eff_width();
        if (hold) hold_req_cnt++;
        for (k = 0; k < n_items; k++) begin
            if (pause && k == n_items / 2) settle_all();
            backlog_add(make_request(w, hold && k < 200));
        end
        backlog_add(make_read($urandom_range(0, w - 1)));
        settle_all();
        repeat (50) @(negedge aclk);
    endtask

    // stimulus
    initial begin
        int k, w;
        foreach (cov_row[i]) cov_row[i] = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed beats at the reset row width
        idle_mode = IDLE_TX27_RX79;
        for (k = 0; k < 6; k++) backlog_add(make_span(16, 5 * PIX_UNIT + 240));
        backlog_add(make_read(0));        // edge saturated
        backlog_add(make_read(2));        // interior wrapped
        backlog_add(make_read(5));
        backlog_add(make_span(7 * PIX_UNIT + 5, 7 * PIX_UNIT + 240));
        backlog_add(make_span(X_MIN, 2 * PIX_UNIT + 255));
        backlog_add(make_span(X_MAX, X_MAX));
        backlog_add(make_span(-1000, -1));
        backlog_add(make_span(3 * PIX_UNIT, 2 * PIX_UNIT));
        backlog_add(make_span(1021 * PIX_UNIT, X_MAX));
        backlog_add('{req: REQ_UNUSED, sx: '1, ex: '1, col: '1});
        backlog_add(make_read(1023));
        backlog_add(make_read(0));
        backlog_add(make_read(7));
        backlog_add(make_read(1021));
        backlog_add('{req: REQ_CLEAR, sx: '0, ex: '0, col: '0});
        backlog_add(make_read(2));
        backlog_add(make_span(0, 0));
        backlog_add(make_span(0, X_MAX));
        backlog_add(make_read(0));
        backlog_add(make_read(512));
        w = eff_width();
        for (k = 0; k < 160; k++) backlog_add(make_request(w, 1'b0));
        backlog_add(make_read(1));
        settle_all();
        repeat (50) @(negedge aclk);

        // width 0 acts as 1, 2047 as the full row
        run_phase(IDLE_TX27_RX79, 11'd0, 120, 1'b0, 1'b0);
        run_phase(IDLE_TX79_RX27, 11'd2047, 170, 1'b0, 1'b1);
        run_phase(IDLE_TX79_RX27, 11'd1, 90, 1'b0, 1'b0);
        run_phase(IDLE_NONE, ROW_CFG_W'($urandom_range(2, 1022)), 180, 1'b1, 1'b0);
        run_phase(IDLE_NONE, 11'd1024, 200, 1'b0, 1'b0);
        run_phase(IDLE_NONE, 11'd1023, 170, 1'b0, 1'b0);

        repeat (200) @(negedge aclk);
        $display("covered %0d spans, %0d reads, %0d clears, %0d unused requests",
                 n_spans, n_reads, n_clears, n_unused);
        $display("over seven row width settings with stalls on both sides; %0d reads checked",
                 n_checked);
        if (err_count == 0 && pixel_expect.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* row_span_coverage_accumulator.f */
rtl/rsca_pkg.sv
rtl/rsca_cmd_fifo.sv
rtl/rsca_front.sv
rtl/rsca_back.sv
rtl/row_span_coverage_accumulator.sv
tb/sv/tb_row_span_coverage_accumulator.sv
